// File: rtl/apsc_pkg.sv
// Package for the arm position slew controller: word types, opcodes, mode codes,
// register indexes and reset constants.
// No dependencies; used by the channel interfaces and the top level.
package apsc_pkg;

   localparam int PosFracBitsDefault = 10;

   localparam int PosW   = 16;
   localparam int DriveW = 8;
   localparam int CapW   = 7;
   localparam int GainW  = 12;
   localparam int TolW   = 10;
   localparam int ModeW  = 4;
   localparam int CodeW  = 3;
   localparam int NumPresets = 6;

   typedef logic signed [PosW-1:0]   pos_type;
   typedef logic signed [DriveW-1:0] drive_type;
   typedef logic [CapW-1:0]          cap_type;
   typedef logic [GainW-1:0]         gain_type;
   typedef logic [TolW-1:0]          tol_type;
   typedef logic [ModeW-1:0]         mode_type;
   typedef logic [CodeW-1:0]         code_type;
   typedef logic [1:0]               chain_type;
   typedef logic [2:0]               reg_idx_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_MOVE   = 2'd1,
      OP_PRESET = 2'd2,
      OP_HOME   = 2'd3
   } op_type;

   localparam mode_type MODE_IDLE        = 4'd0;
   localparam mode_type MODE_LOW_TOWER   = 4'd1;
   localparam mode_type MODE_MID_TOWER   = 4'd2;
   localparam mode_type MODE_LOW_MANUAL  = 4'd3;
   localparam mode_type MODE_LOW_DESCORE = 4'd4;
   localparam mode_type MODE_MID_DESCORE = 4'd5;
   localparam mode_type MODE_LOW_ALT     = 4'd6;
   localparam mode_type MODE_HOME        = 4'd10;
   localparam mode_type MODE_MOVE        = 4'd11;

   localparam code_type CODE_IDLE    = 3'd0;
   localparam code_type CODE_LOW     = 3'd1;
   localparam code_type CODE_MID     = 3'd2;
   localparam code_type CODE_INVALID = 3'd7;

   localparam chain_type CHAIN_NONE = 2'd0;

   localparam reg_idx_type REG_GAIN         = 3'd0;
   localparam reg_idx_type REG_TOLERANCE    = 3'd1;
   localparam reg_idx_type REG_POS_BOTTOM   = 3'd2;
   localparam reg_idx_type REG_POS_LOW      = 3'd3;
   localparam reg_idx_type REG_POS_MID      = 3'd4;
   localparam reg_idx_type REG_POS_LOW_MAN  = 3'd5;
   localparam reg_idx_type REG_POS_LOW_DSC  = 3'd6;
   localparam reg_idx_type REG_POS_MID_DSC  = 3'd7;

   localparam gain_type  GAIN_RESET   = 12'd350;
   localparam cap_type   PRESET_SPEED = 7'd127;
   localparam cap_type   PRESET_STEP  = 7'd9;
   localparam cap_type   TOWER_STEP   = 7'd50;
   localparam drive_type HOME_DRIVE   = -8'sd100;
   localparam drive_type DRIVE_ZERO   = 8'sd0;

   typedef struct packed {
      op_type   opcode;
      pos_type  raw_position;
      logic     limit_hit;
      pos_type  goal_position;
      cap_type  speed_cap;
      cap_type  slew_step;
      code_type preset_code;
   } req_word_type;

   typedef struct packed {
      drive_type drive;
      logic      settled;
      mode_type  mode_now;
      pos_type   position;
   } rsp_word_type;

endpackage

// File: rtl/apsc_ifs.sv
// Channel interfaces for the arm position slew controller: request and response words.
// Depends on apsc_pkg for field types.
interface apsc_req_if;
   logic                 valid;
   logic                 ready;
   apsc_pkg::op_type     opcode;
   apsc_pkg::pos_type    raw_position;
   logic                 limit_hit;
   apsc_pkg::pos_type    goal_position;
   apsc_pkg::cap_type    speed_cap;
   apsc_pkg::cap_type    slew_step;
   apsc_pkg::code_type   preset_code;

   modport source (
      output valid, opcode, raw_position, limit_hit, goal_position, speed_cap,
             slew_step, preset_code,
      input  ready
   );
   modport sink (
      input  valid, opcode, raw_position, limit_hit, goal_position, speed_cap,
             slew_step, preset_code,
      output ready
   );
endinterface

interface apsc_rsp_if;
   logic                 valid;
   logic                 ready;
   apsc_pkg::drive_type  drive;
   logic                 settled;
   apsc_pkg::mode_type   mode_now;
   apsc_pkg::pos_type    position;

   modport source (output valid, drive, settled, mode_now, position, input ready);
   modport sink   (input valid, drive, settled, mode_now, position, output ready);
endinterface

// File: rtl/arm_position_p_slew_controller_top.sv
// Top level of the arm position slew controller: input register, single-pass update
// of the regulator state, result register and APB register file.
// Depends on apsc_pkg and the channel interfaces in apsc_ifs.sv.
//
//   channel   ports        direction   word
//   req       req_chan     in          opcode, raw_position, limit_hit, goal/speed/step, code
//   rsp       rsp_chan     out         drive, settled, mode_now, position
//   csr       csr_*        in/out      APB registers 0..7, 32-bit data
//
// Each word passes through the input register, then through the error multiply and slew
// update into the result register. One word is accepted every cycle unless the result
// is stalled; each word sees the regulator state left by the word before it.
// Synchronous reset loads the register and state reset values; no clearing pass.
// A stalled result holds in the result register while one more word waits in the input
// register; req ready drops only when both are full.
module arm_position_p_slew_controller_top #(
   parameter int POS_FRAC_BITS = apsc_pkg::PosFracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   apsc_req_if.sink    req_chan,
   apsc_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import apsc_pkg::*;

   localparam int TolRaw   = ((1 << POS_FRAC_BITS) + 5) / 10;
   localparam int TolSat   = (TolRaw > 1023) ? 1023 : TolRaw;
   localparam tol_type TOL_RESET = tol_type'(TolSat);
   localparam int ProdW    = 30;
   localparam int LimW     = 10 + POS_FRAC_BITS;
   localparam int CmpW     = ((ProdW > LimW) ? ProdW : LimW) + 1;

   // input stage
   logic         a_valid_ff, a_valid_in;
   req_word_type a_word_ff, a_word_in;
   logic         a_adv;

   // result stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // configuration
   gain_type  gain_ff, gain_in;
   tol_type   tolerance_ff, tolerance_in;
   pos_type   preset_ff [NumPresets];
   pos_type   preset_in [NumPresets];

   // regulator state
   mode_type  mode_ff, mode_in;
   chain_type next_preset_ff, next_preset_in;
   pos_type   target_ff, target_in;
   cap_type   speed_ff, speed_in;
   cap_type   step_ff, step_in;
   drive_type slew_ff, slew_in;
   logic      settled_ff, settled_in;
   pos_type   home_offset_ff, home_offset_in;
   drive_type motor_ff, motor_in;

   // datapath
   logic                    cfg_we;
   reg_idx_type             cfg_idx;
   pos_type                 pos_rel;
   logic signed [16:0]      err;
   logic signed [ProdW-1:0] prod;
   logic signed [CmpW-1:0]  prod_w;
   logic signed [CmpW-1:0]  prod_neg;
   logic signed [9:0]       slew10;
   logic signed [9:0]       step10;
   logic signed [9:0]       slew_plus;
   logic signed [9:0]       slew_minus;
   logic signed [CmpW-1:0]  hi_lim;
   logic signed [CmpW-1:0]  lo_lim;
   logic signed [CmpW-1:0]  q_pos;
   logic signed [CmpW-1:0]  q_neg;
   logic signed [9:0]       slew_new;
   logic signed [9:0]       slew_sat;
   logic signed [9:0]       slew_clamp;
   logic signed [9:0]       spd10;
   logic signed [16:0]      tol17;
   logic                    in_tol;
   logic                    bottom_hit;
   code_type                code_eff;

   assign a_adv = a_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_adv;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_word_in  = a_word_ff;
      if (req_chan.valid && req_chan.ready) begin
         a_valid_in = 1'b1;
         a_word_in.opcode        = req_chan.opcode;
         a_word_in.raw_position  = req_chan.raw_position;
         a_word_in.limit_hit     = req_chan.limit_hit;
         a_word_in.goal_position = req_chan.goal_position;
         a_word_in.speed_cap     = req_chan.speed_cap;
         a_word_in.slew_step     = req_chan.slew_step;
         a_word_in.preset_code   = req_chan.preset_code;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
   end

   // tick arithmetic
   always_comb begin
      pos_rel    = a_word_ff.raw_position - home_offset_ff;
      err        = 17'(target_ff) - 17'(pos_rel);
      prod       = ProdW'(err) * ProdW'(signed'({1'b0, gain_ff}));
      prod_w     = CmpW'(prod);
      prod_neg   = -prod_w;
      slew10     = 10'(slew_ff);
      step10     = signed'({3'b000, step_ff});
      spd10      = signed'({3'b000, speed_ff});
      slew_plus  = slew10 + step10;
      slew_minus = slew10 - step10;
      hi_lim     = CmpW'(slew_plus) <<< POS_FRAC_BITS;
      lo_lim     = CmpW'(slew_minus) <<< POS_FRAC_BITS;
      q_pos      = prod_w >>> POS_FRAC_BITS;
      q_neg      = -(prod_neg >>> POS_FRAC_BITS);
      if (prod_w > 0) begin
         slew_new = (prod_w > hi_lim) ? slew_plus : q_pos[9:0];
      end else if (prod_w < 0) begin
         slew_new = (prod_w < lo_lim) ? slew_minus : q_neg[9:0];
      end else begin
         slew_new = slew10;
      end
      if (slew_new > 10'sd127) begin
         slew_sat = 10'sd127;
      end else if (slew_new < -10'sd127) begin
         slew_sat = -10'sd127;
      end else begin
         slew_sat = slew_new;
      end
      if (slew_new > spd10) begin
         slew_clamp = spd10;
      end else if (slew_new < -spd10) begin
         slew_clamp = -spd10;
      end else begin
         slew_clamp = slew_new;
      end
      tol17      = signed'({7'b0, tolerance_ff});
      in_tol     = (err > -tol17) && (err < tol17);
      bottom_hit = (target_ff == preset_ff[0]) && a_word_ff.limit_hit;
      code_eff   = (a_word_ff.preset_code == CODE_INVALID) ? CODE_IDLE
                                                           : a_word_ff.preset_code;
   end

   assign cfg_we  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = csr_paddr[4:2];

   // state update
   always_comb begin
      gain_in        = gain_ff;
      tolerance_in   = tolerance_ff;
      preset_in      = preset_ff;
      mode_in        = mode_ff;
      next_preset_in = next_preset_ff;
      target_in      = target_ff;
      speed_in       = speed_ff;
      step_in        = step_ff;
      slew_in        = slew_ff;
      settled_in     = settled_ff;
      home_offset_in = home_offset_ff;
      motor_in       = motor_ff;

      if (cfg_we) begin
         case (cfg_idx)
            REG_GAIN:        gain_in      = csr_pwdata[GainW-1:0];
            REG_TOLERANCE:   tolerance_in = csr_pwdata[TolW-1:0];
            REG_POS_BOTTOM:  preset_in[0] = csr_pwdata[PosW-1:0];
            REG_POS_LOW:     preset_in[1] = csr_pwdata[PosW-1:0];
            REG_POS_MID:     preset_in[2] = csr_pwdata[PosW-1:0];
            REG_POS_LOW_MAN: preset_in[3] = csr_pwdata[PosW-1:0];
            REG_POS_LOW_DSC: preset_in[4] = csr_pwdata[PosW-1:0];
            REG_POS_MID_DSC: preset_in[5] = csr_pwdata[PosW-1:0];
            default: ;
         endcase
      end

      if (a_adv) begin
         case (a_word_ff.opcode)
            OP_TICK: begin
               case (mode_ff)
                  MODE_LOW_TOWER, MODE_LOW_ALT: begin
                     target_in = preset_ff[1];
                     step_in   = TOWER_STEP;
                     if (mode_ff == MODE_LOW_TOWER) begin
                        next_preset_in = CHAIN_NONE;
                     end
                     mode_in = MODE_MOVE;
                  end
                  MODE_MID_TOWER: begin
                     target_in      = preset_ff[2];
                     step_in        = TOWER_STEP;
                     next_preset_in = CHAIN_NONE;
                     mode_in        = MODE_MOVE;
                  end
                  MODE_LOW_MANUAL: begin
                     target_in = preset_ff[3];
                     mode_in   = MODE_MOVE;
                  end
                  MODE_LOW_DESCORE: begin
                     target_in = preset_ff[4];
                     mode_in   = MODE_MOVE;
                  end
                  MODE_MID_DESCORE: begin
                     target_in = preset_ff[5];
                     mode_in   = MODE_MOVE;
                  end
                  MODE_HOME: begin
                     motor_in = HOME_DRIVE;
                     if (a_word_ff.limit_hit) begin
                        home_offset_in = a_word_ff.raw_position;
                        motor_in       = DRIVE_ZERO;
                        settled_in     = 1'b1;
                        mode_in        = MODE_MOVE;
                     end
                  end
                  MODE_MOVE: begin
                     if (in_tol || bottom_hit) begin
                        if (next_preset_ff != CHAIN_NONE) begin
                           mode_in = mode_type'(next_preset_ff);
                           slew_in = slew_sat[7:0];
                        end else begin
                           tolerance_in   = TOL_RESET;
                           slew_in        = DRIVE_ZERO;
                           motor_in       = DRIVE_ZERO;
                           settled_in     = 1'b1;
                           next_preset_in = CHAIN_NONE;
                           mode_in        = MODE_IDLE;
                        end
                     end else begin
                        slew_in  = slew_clamp[7:0];
                        motor_in = slew_clamp[7:0];
                     end
                  end
                  default: ;
               endcase
            end
            OP_MOVE: begin
               target_in      = a_word_ff.goal_position;
               speed_in       = a_word_ff.speed_cap;
               step_in        = a_word_ff.slew_step;
               settled_in     = 1'b0;
               slew_in        = DRIVE_ZERO;
               motor_in       = DRIVE_ZERO;
               next_preset_in = CHAIN_NONE;
               mode_in        = MODE_MOVE;
            end
            OP_PRESET: begin
               target_in  = preset_ff[0];
               speed_in   = PRESET_SPEED;
               step_in    = PRESET_STEP;
               slew_in    = DRIVE_ZERO;
               motor_in   = DRIVE_ZERO;
               settled_in = 1'b0;
               if (code_eff == CODE_LOW || code_eff == CODE_MID) begin
                  next_preset_in = code_eff[1:0];
                  mode_in        = MODE_MOVE;
               end else begin
                  next_preset_in = CHAIN_NONE;
                  mode_in        = mode_type'(code_eff);
               end
            end
            OP_HOME: begin
               target_in      = preset_ff[0];
               settled_in     = 1'b0;
               next_preset_in = CHAIN_NONE;
               mode_in        = MODE_HOME;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (a_adv) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.drive    = motor_in;
         rsp_word_in.settled  = settled_in;
         rsp_word_in.mode_now = mode_in;
         rsp_word_in.position = (a_word_ff.opcode == OP_TICK) ? pos_rel : pos_type'(0);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_word_ff   <= a_word_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         gain_ff        <= GAIN_RESET;
         tolerance_ff   <= TOL_RESET;
         for (int i = 0; i < NumPresets; i++) begin
            preset_ff[i] <= '0;
         end
         mode_ff        <= MODE_IDLE;
         next_preset_ff <= CHAIN_NONE;
         target_ff      <= '0;
         speed_ff       <= '0;
         step_ff        <= PRESET_STEP;
         slew_ff        <= DRIVE_ZERO;
         settled_ff     <= 1'b1;
         home_offset_ff <= '0;
         motor_ff       <= DRIVE_ZERO;
      end else begin
         a_valid_ff     <= a_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         gain_ff        <= gain_in;
         tolerance_ff   <= tolerance_in;
         preset_ff      <= preset_in;
         mode_ff        <= mode_in;
         next_preset_ff <= next_preset_in;
         target_ff      <= target_in;
         speed_ff       <= speed_in;
         step_ff        <= step_in;
         slew_ff        <= slew_in;
         settled_ff     <= settled_in;
         home_offset_ff <= home_offset_in;
         motor_ff       <= motor_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.drive    = rsp_word_ff.drive;
   assign rsp_chan.settled  = rsp_word_ff.settled;
   assign rsp_chan.mode_now = rsp_word_ff.mode_now;
   assign rsp_chan.position = rsp_word_ff.position;

   assign csr_pready = 1'b1;

   always_comb begin
      case (cfg_idx)
         REG_GAIN:        csr_prdata = 32'(gain_ff);
         REG_TOLERANCE:   csr_prdata = 32'(tolerance_ff);
         REG_POS_BOTTOM:  csr_prdata = 32'(preset_ff[0]);
         REG_POS_LOW:     csr_prdata = 32'(preset_ff[1]);
         REG_POS_MID:     csr_prdata = 32'(preset_ff[2]);
         REG_POS_LOW_MAN: csr_prdata = 32'(preset_ff[3]);
         REG_POS_LOW_DSC: csr_prdata = 32'(preset_ff[4]);
         REG_POS_MID_DSC: csr_prdata = 32'(preset_ff[5]);
         default:         csr_prdata = '0;
      endcase
   end

endmodule
